FILE: src/tp3d_pkg.sv
// ----------------------------------------------------------------------------
// tp3d_pkg
// Shared types and constants of the 3D turtle path interpreter.
// ----------------------------------------------------------------------------
`default_nettype none

package tp3d_pkg;

    // fixed field widths
    localparam int POS_W = 40;
    localparam int ANG_W = 18;
    localparam int CFG_W = 64;
    localparam int IDX_W = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_COS  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_SIN  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MOVE = 2'd2;
    localparam logic [IDX_W-1:0] CFG_DRAW = 2'd3;

    // operator symbol codes
    localparam logic [7:0] SYM_TURN_L  = 8'h2B; // +
    localparam logic [7:0] SYM_TURN_R  = 8'h2D; // -
    localparam logic [7:0] SYM_PITCH_D = 8'h5E; // ^
    localparam logic [7:0] SYM_PITCH_U = 8'h26; // &
    localparam logic [7:0] SYM_ROLL_L  = 8'h5C; // backslash
    localparam logic [7:0] SYM_ROLL_R  = 8'h2F; // /
    localparam logic [7:0] SYM_REVERSE = 8'h7C; // |
    localparam logic [7:0] SYM_PUSH    = 8'h28; // (
    localparam logic [7:0] SYM_POP     = 8'h29; // )

    // result status codes
    localparam logic [1:0] ST_SEGMENT  = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_UNDERFLW = 2'd2;
    localparam logic [1:0] ST_SATURATE = 2'd3;

    // decoded operation codes
    localparam logic [2:0] OP_MOVE = 3'd0;
    localparam logic [2:0] OP_ROT  = 3'd1;
    localparam logic [2:0] OP_REV  = 3'd2;
    localparam logic [2:0] OP_PUSH = 3'd3;
    localparam logic [2:0] OP_POP  = 3'd4;
    localparam logic [2:0] OP_HOME = 3'd5;

    // rotation vector pairs
    localparam logic [1:0] PAIR_HL = 2'd0;
    localparam logic [1:0] PAIR_HU = 2'd1;
    localparam logic [1:0] PAIR_LU = 2'd2;

    typedef struct packed {
        logic       action;
        logic [7:0] symbol;
    } sym_item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] start_z;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
        logic signed [POS_W-1:0] end_z;
        logic [1:0]              status;
    } seg_item_t;

    typedef struct packed {
        logic [2:0] code;
        logic       draw;
        logic [1:0] pair;
        logic       neg;
    } op_t;

endpackage

`default_nettype wire

FILE: src/tp3d_ram.sv
// ----------------------------------------------------------------------------
// tp3d_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tp3d_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

FILE: src/tp3d_front.sv
// ----------------------------------------------------------------------------
// tp3d_front
// Symbol decoder: classifies a request into a turtle operation.
// ----------------------------------------------------------------------------
`default_nettype none

module tp3d_front (
    input  wire tp3d_pkg::sym_item_t sym_data,
    input  wire logic [63:0]         move_mask,
    input  wire logic [63:0]         draw_mask,
    output tp3d_pkg::op_t            op,
    output logic                     keep
);
    import tp3d_pkg::*;

    logic is_alpha;

    // alphabet move symbols are codes 64 to 127
    assign is_alpha = (sym_data.symbol[7:6] == 2'b01);

    // move mask wins over operator symbols
    always_comb
    begin
        op   = '0;
        keep = 1'b1;
        if (sym_data.action)
        begin
            op.code = OP_HOME;
        end
        else if (is_alpha && move_mask[sym_data.symbol[5:0]])
        begin
            op.code = OP_MOVE;
            op.draw = draw_mask[sym_data.symbol[5:0]];
        end
        else
        begin
            unique case (sym_data.symbol)
                SYM_TURN_L:  begin op.code = OP_ROT; op.pair = PAIR_HL; end
                SYM_TURN_R:  begin op.code = OP_ROT; op.pair = PAIR_HL; op.neg = 1'b1; end
                SYM_PITCH_D: begin op.code = OP_ROT; op.pair = PAIR_HU; end
                SYM_PITCH_U: begin op.code = OP_ROT; op.pair = PAIR_HU; op.neg = 1'b1; end
                SYM_ROLL_R:  begin op.code = OP_ROT; op.pair = PAIR_LU; end
                SYM_ROLL_L:  begin op.code = OP_ROT; op.pair = PAIR_LU; op.neg = 1'b1; end
                SYM_REVERSE: op.code = OP_REV;
                SYM_PUSH:    op.code = OP_PUSH;
                SYM_POP:     op.code = OP_POP;
                default:     keep = 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/tp3d_queue.sv
// ----------------------------------------------------------------------------
// tp3d_queue
// Two entry operation queue between decoder and execution unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tp3d_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire tp3d_pkg::op_t push_op,
    output logic               full,
    output logic               q_valid,
    input  wire logic          q_ready,
    output tp3d_pkg::op_t      q_op
);
    import tp3d_pkg::*;

    op_t        ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_op    = ent_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_valid && q_ready;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            ent_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

FILE: src/tp3d_back.sv
// ----------------------------------------------------------------------------
// tp3d_back
// Execution unit: turtle state, rotations, moves, save stack, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tp3d_back #(
    parameter int FRAC_BITS   = 16,
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    output logic                              q_ready,
    input  wire tp3d_pkg::op_t                q_op,
    input  wire logic signed [tp3d_pkg::ANG_W-1:0] cos_angle,
    input  wire logic signed [tp3d_pkg::ANG_W-1:0] sin_angle,
    output logic                              seg_valid,
    input  wire logic                         seg_ready,
    output tp3d_pkg::seg_item_t               seg_data
);
    import tp3d_pkg::*;

    localparam int CW = FRAC_BITS + 2;
    localparam int SN = ANG_W + 1;
    localparam int SW = CW + SN + 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int RW = 9 * CW + 3 * POS_W;

    localparam logic signed [SW-1:0] ONE_W  = 1;
    localparam logic signed [SW-1:0] HALF_W = ONE_W <<< (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] CMAX_W = (ONE_W <<< (CW - 1)) - ONE_W;
    localparam logic signed [SW-1:0] CMIN_W = -CMAX_W - ONE_W;
    localparam logic signed [CW-1:0] CMAX   = CMAX_W[CW-1:0];
    localparam logic signed [CW-1:0] CMIN   = CMIN_W[CW-1:0];
    localparam logic signed [CW-1:0] C_ONE  = CW'(ONE_W <<< FRAC_BITS);
    localparam logic signed [POS_W-1:0] PMAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] PMIN = {1'b1, {(POS_W-1){1'b0}}};

    // round half up at the fraction point, then clamp to component range
    function automatic logic signed [CW-1:0] rnd_sat(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        t = (v + HALF_W) >>> FRAC_BITS;
        if (t > CMAX_W)
            return CMAX;
        else if (t < CMIN_W)
            return CMIN;
        else
            return t[CW-1:0];
    endfunction

    function automatic logic signed [CW-1:0] neg_sat(input logic signed [CW-1:0] v);
        if (v == CMIN)
            return CMAX;
        else
            return -v;
    endfunction

    logic signed [CW-1:0]    h_reg [3], h_next [3];
    logic signed [CW-1:0]    l_reg [3], l_next [3];
    logic signed [CW-1:0]    u_reg [3], u_next [3];
    logic signed [POS_W-1:0] p_reg [3], p_next [3];
    logic [LW-1:0]           level_reg, level_next;
    logic                    pop_wait_reg, pop_wait_next;
    logic                    seg_valid_reg, seg_valid_next;
    seg_item_t               seg_data_reg, seg_data_next;

    logic                    q_fire;
    logic                    emit;
    seg_item_t               res;
    logic signed [CW-1:0]    rot_a [3], rot_b [3], new_a [3], new_b [3];
    logic signed [SN-1:0]    s_eff, c_eff;
    logic signed [POS_W-1:0] mv_pos [3];
    logic                    mv_hit;
    logic [LW-1:0]           lvl_dec;
    logic                    ram_we;
    logic [RW-1:0]           ram_wdata, ram_rdata;

    assign q_ready   = !pop_wait_reg && (!seg_valid_reg || seg_ready);
    assign q_fire    = q_valid && q_ready;
    assign seg_valid = seg_valid_reg;
    assign seg_data  = seg_data_reg;
    assign lvl_dec   = level_reg - LW'(1);

    // rotation datapath: pick the vector pair, four multiplies per component
    always_comb
    begin
        c_eff = SN'(cos_angle);
        s_eff = q_op.neg ? -SN'(sin_angle) : SN'(sin_angle);
        for (int k = 0; k < 3; k++)
        begin
            case (q_op.pair)
                PAIR_HU: begin rot_a[k] = h_reg[k]; rot_b[k] = u_reg[k]; end
                PAIR_LU: begin rot_a[k] = l_reg[k]; rot_b[k] = u_reg[k]; end
                default: begin rot_a[k] = h_reg[k]; rot_b[k] = l_reg[k]; end
            endcase
            new_a[k] = rnd_sat(SW'(rot_a[k]) * SW'(c_eff) + SW'(rot_b[k]) * SW'(s_eff));
            new_b[k] = rnd_sat(SW'(rot_b[k]) * SW'(c_eff) - SW'(rot_a[k]) * SW'(s_eff));
        end
    end

    // move datapath: saturating step along heading
    always_comb
    begin
        logic signed [POS_W:0] sum;
        mv_hit = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            sum = (POS_W+1)'(p_reg[k]) + (POS_W+1)'(h_reg[k]);
            if (sum[POS_W] != sum[POS_W-1])
            begin
                mv_hit    = 1'b1;
                mv_pos[k] = sum[POS_W] ? PMIN : PMAX;
            end
            else
            begin
                mv_pos[k] = sum[POS_W-1:0];
            end
        end
    end

    // save stack entry packing
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ram_wdata[k*CW +: CW]            = h_reg[k];
            ram_wdata[(3+k)*CW +: CW]        = l_reg[k];
            ram_wdata[(6+k)*CW +: CW]        = u_reg[k];
            ram_wdata[9*CW + k*POS_W +: POS_W] = p_reg[k];
        end
    end

    assign ram_we = q_fire && (q_op.code == OP_PUSH) && (level_reg < LW'(STACK_DEPTH));

    tp3d_ram #(
        .WIDTH  (RW),
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (AW)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (level_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (lvl_dec[AW-1:0]),
        .rdata (ram_rdata)
    );

    // operation execute
    always_comb
    begin
        h_next        = h_reg;
        l_next        = l_reg;
        u_next        = u_reg;
        p_next        = p_reg;
        level_next    = level_reg;
        pop_wait_next = 1'b0;
        emit          = 1'b0;
        res           = '0;
        if (pop_wait_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                h_next[k] = ram_rdata[k*CW +: CW];
                l_next[k] = ram_rdata[(3+k)*CW +: CW];
                u_next[k] = ram_rdata[(6+k)*CW +: CW];
                p_next[k] = ram_rdata[9*CW + k*POS_W +: POS_W];
            end
        end
        else if (q_fire)
        begin
            unique case (q_op.code)
                OP_MOVE:
                begin
                    p_next        = mv_pos;
                    emit          = q_op.draw || mv_hit;
                    res.start_x   = p_reg[0];
                    res.start_y   = p_reg[1];
                    res.start_z   = p_reg[2];
                    res.end_x     = mv_pos[0];
                    res.end_y     = mv_pos[1];
                    res.end_z     = mv_pos[2];
                    res.status    = mv_hit ? ST_SATURATE : ST_SEGMENT;
                end
                OP_ROT:
                begin
                    case (q_op.pair)
                        PAIR_HU: begin h_next = new_a; u_next = new_b; end
                        PAIR_LU: begin l_next = new_a; u_next = new_b; end
                        default: begin h_next = new_a; l_next = new_b; end
                    endcase
                end
                OP_REV:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        h_next[k] = neg_sat(h_reg[k]);
                        l_next[k] = neg_sat(l_reg[k]);
                    end
                end
                OP_PUSH:
                begin
                    if (level_reg < LW'(STACK_DEPTH))
                    begin
                        level_next = level_reg + LW'(1);
                    end
                    else
                    begin
                        emit       = 1'b1;
                        res.status = ST_OVERFLOW;
                    end
                end
                OP_POP:
                begin
                    if (level_reg != '0)
                    begin
                        level_next    = lvl_dec;
                        pop_wait_next = 1'b1;
                    end
                    else
                    begin
                        emit       = 1'b1;
                        res.status = ST_UNDERFLW;
                    end
                end
                OP_HOME:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        h_next[k] = (k == 0) ? C_ONE : '0;
                        l_next[k] = (k == 1) ? C_ONE : '0;
                        u_next[k] = (k == 2) ? C_ONE : '0;
                        p_next[k] = '0;
                    end
                    level_next = '0;
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    // result register
    always_comb
    begin
        seg_data_next = seg_data_reg;
        if (q_fire && emit)
        begin
            seg_valid_next = 1'b1;
            seg_data_next  = res;
        end
        else if (seg_ready)
        begin
            seg_valid_next = 1'b0;
        end
        else
        begin
            seg_valid_next = seg_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                h_reg[k] <= (k == 0) ? C_ONE : '0;
                l_reg[k] <= (k == 1) ? C_ONE : '0;
                u_reg[k] <= (k == 2) ? C_ONE : '0;
                p_reg[k] <= '0;
            end
            level_reg     <= '0;
            pop_wait_reg  <= 1'b0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            h_reg         <= h_next;
            l_reg         <= l_next;
            u_reg         <= u_next;
            p_reg         <= p_next;
            level_reg     <= level_next;
            pop_wait_reg  <= pop_wait_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_data_reg <= seg_data_next;
    end

`ifndef NO_ASSERTIONS
    // the restore wait state is never entered twice in a row
    a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        pop_wait_reg |=> !pop_wait_reg)
        else $error("restore wait longer than one cycle");

    // stack level stays within depth
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // a valid pop enters the restore cycle
    a_pop_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (q_fire && q_op.code == OP_POP && level_reg != '0) |=> pop_wait_reg)
        else $error("pop did not start restore");

    // no request taken during restore
    a_no_take_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        pop_wait_reg |-> !q_ready)
        else $error("request taken during restore");
`endif

endmodule

`default_nettype wire

FILE: src/turtle_path_3d_top.sv
// ----------------------------------------------------------------------------
// turtle_path_3d_top
// 3D turtle interpreter over a rewritten symbol stream, emitting segments.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  --------+----------------------------------+------------------------------
//  sym     | sym_valid / sym_ready            | sym_data (action, symbol)
//  seg     | seg_valid / seg_ready            | seg_data (start, end, status)
//  cfg     | cfg_we                           | cfg_index, cfg_data
//
//  one request per cycle sustained unless seg_ready stalls; a restore ')' holds
//  off the next request for the registered read of the save stack RAM
//  a result is registered and appears in the cycle after its request leaves the two entry queue
//  rst_n is asynchronous and puts the turtle home with an empty stack
//  sym_ready drops only when the queue is full, seg_ready stalls the back end
// ----------------------------------------------------------------------------
`default_nettype none

module turtle_path_3d_top #(
    parameter int FRAC_BITS   = 16,
    parameter int STACK_DEPTH = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            sym_valid,
    output logic                                 sym_ready,
    input  wire tp3d_pkg::sym_item_t             sym_data,
    output logic                                 seg_valid,
    input  wire logic                            seg_ready,
    output tp3d_pkg::seg_item_t                  seg_data,
    input  wire logic                            cfg_we,
    input  wire logic [tp3d_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [tp3d_pkg::CFG_W-1:0]      cfg_data
);
    import tp3d_pkg::*;

    logic signed [ANG_W-1:0] cos_reg, sin_reg;
    logic [63:0]             move_reg, draw_reg;
    op_t                     dec_op, q_op;
    logic                    dec_keep;
    logic                    q_full, q_valid, q_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg  <= ANG_W'(65536);
            sin_reg  <= '0;
            move_reg <= '0;
            draw_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_COS:  cos_reg  <= cfg_data[ANG_W-1:0];
                CFG_SIN:  sin_reg  <= cfg_data[ANG_W-1:0];
                CFG_MOVE: move_reg <= cfg_data;
                CFG_DRAW: draw_reg <= cfg_data;
                default:  move_reg <= move_reg;
            endcase
        end
    end

    assign sym_ready = !q_full;

    // decode
    tp3d_front u_front (
        .sym_data  (sym_data),
        .move_mask (move_reg),
        .draw_mask (draw_reg),
        .op        (dec_op),
        .keep      (dec_keep)
    );

    // operation queue
    tp3d_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (sym_valid && dec_keep),
        .push_op (dec_op),
        .full    (q_full),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_op    (q_op)
    );

    // execute
    tp3d_back #(
        .FRAC_BITS   (FRAC_BITS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_op      (q_op),
        .cos_angle (cos_reg),
        .sin_angle (sin_reg),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg_data  (seg_data)
    );

endmodule

`default_nettype wire
